[rtl/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants of the calendar seconds converter
// Sequencer state type, calendar limits and the per-month second counts.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

	localparam int unsigned SECS_W = 36;
	localparam int unsigned YEAR_W = 12;

	localparam logic [YEAR_W-1:0] YEAR_FIRST = 12'd1600;
	localparam logic [YEAR_W-1:0] YEAR_LAST  = 12'd3000;

	// 3000-12-31 23:59:59 counted from 1600-01-01 00:00:00
	localparam logic [SECS_W-1:0] SECS_MAX       = 36'd44211311999;
	localparam logic [SECS_W-1:0] SECS_PER_DAY   = 36'd86400;
	localparam logic [SECS_W-1:0] SECS_PER_HOUR  = 36'd3600;
	localparam logic [SECS_W-1:0] SECS_PER_MIN   = 36'd60;
	localparam logic [SECS_W-1:0] SECS_YEAR      = 36'd31536000;
	localparam logic [SECS_W-1:0] SECS_YEAR_LEAP = 36'd31622400;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// Sequencer phases: the year to minute phases add or remove one calendar unit per cycle
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_SEC,
		ST_LOAD
	} csc_state_t;

	// Length of a month in days
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		unique case (m)
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			MONTH_FEB:               d = leap ? 5'd29 : 5'd28;
			4'd0:                    d = 5'd0;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

	// Length of a month in seconds
	function automatic logic [SECS_W-1:0] month_secs(input logic [3:0] m, input logic leap);
		logic [SECS_W-1:0] s;
		unique case (month_days(m, leap))
			5'd31:   s = 36'd2678400;
			5'd30:   s = 36'd2592000;
			5'd29:   s = 36'd2505600;
			5'd28:   s = 36'd2419200;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/calendar_seconds_converter.sv]
// ----------------------------------------------------------------------------
// calendar_seconds_converter
// Gregorian date/time to seconds since 1600-01-01 and back, one year, month,
// day, hour or minute per cycle through a single shared add/subtract unit.
// ----------------------------------------------------------------------------
// With func 0 the fields are checked and composed into seconds_out; with
// func 1 seconds_in is split into year/month/day/hour/minute/second. Each
// request transfer gives one response transfer. The running count is stepped by
// one 37-bit add/subtract unit, one year, month, day, hour or minute per
// cycle; leap years are tracked with mod-4/100/400 counters that follow the
// year. Requests with a field outside its fixed range or an out-of-range
// count go straight to the output register load with invalid set; a day
// beyond the length of its month is found at the end of the year walk.
// req_ready is high only while idle; a finished response waits in the
// output register without holding up the next request.
`default_nettype none

module calendar_seconds_converter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  wire                          func,
	input  wire  [csc_pkg::YEAR_W-1:0]   year,
	input  wire  [3:0]                   month,
	input  wire  [4:0]                   day,
	input  wire  [4:0]                   hour,
	input  wire  [5:0]                   minute,
	input  wire  [5:0]                   second,
	input  wire  [csc_pkg::SECS_W-1:0]   seconds_in,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	output logic [csc_pkg::SECS_W-1:0]   seconds_out,
	output logic [csc_pkg::YEAR_W-1:0]   year_out,
	output logic [3:0]                   month_out,
	output logic [4:0]                   day_out,
	output logic [4:0]                   hour_out,
	output logic [5:0]                   minute_out,
	output logic [5:0]                   second_out,
	output logic                         invalid
);
	import csc_pkg::*;

	csc_state_t state_q, state_d;

	// captured request
	logic              func_q;
	logic [YEAR_W-1:0] year_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;
	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [5:0]        second_q;

	// working state
	logic [SECS_W-1:0] acc_q;
	logic [YEAR_W-1:0] y_q;
	logic [1:0]        ym4_q;
	logic [6:0]        ym100_q;
	logic [8:0]        ym400_q;
	logic [3:0]        m_q;
	logic [5:0]        cnt_q;
	logic              bad_q;
	logic [4:0]        day_w_q;
	logic [4:0]        hour_w_q;
	logic [5:0]        min_w_q;
	logic [5:0]        sec_w_q;

	// output register
	logic              rsp_valid_q;
	logic [SECS_W-1:0] seconds_out_q;
	logic [YEAR_W-1:0] year_out_q;
	logic [3:0]        month_out_q;
	logic [4:0]        day_out_q;
	logic [4:0]        hour_out_q;
	logic [5:0]        minute_out_q;
	logic [5:0]        second_out_q;
	logic              invalid_q;

	// control strobes
	logic req_xfer, start_bad;
	logic acc_upd, y_inc, m_inc, cnt_inc, cnt_clr;
	logic sv_day, sv_hour, sv_min, bad_set, out_load;

	// shared unit
	logic              leap;
	logic [SECS_W-1:0] au_op;
	logic [SECS_W:0]   au_res;
	logic              borrow;
	logic [5:0]        cnt_nxt;

	assign req_ready = (state_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign cnt_nxt   = cnt_q + 6'd1;

	// range check at the request transfer; day length is checked after the year walk
	always_comb begin
		if (func) begin
			start_bad = (seconds_in > SECS_MAX);
		end else begin
			start_bad = (year < YEAR_FIRST) || (year > YEAR_LAST)
				|| (month == 4'd0) || (month > MONTH_DEC) || (day == 5'd0)
				|| (hour > 5'd23) || (minute > 6'd59) || (second > 6'd59);
		end
	end

	// leap rule from the residue counters of the current year
	assign leap = (ym4_q == 2'd0) && ((ym100_q != 7'd0) || (ym400_q == 9'd0));

	// operand select and add/subtract: subtract when decomposing
	always_comb begin
		unique case (state_q)
			ST_YEAR:  au_op = leap ? SECS_YEAR_LEAP : SECS_YEAR;
			ST_MONTH: au_op = month_secs(m_q, leap);
			ST_DAY:   au_op = SECS_PER_DAY;
			ST_HOUR:  au_op = SECS_PER_HOUR;
			ST_MIN:   au_op = SECS_PER_MIN;
			ST_SEC:   au_op = {30'd0, second_q};
			default:  au_op = '0;
		endcase
	end

	assign au_res = {1'b0, acc_q} + (func_q ? ~{1'b0, au_op} : {1'b0, au_op})
		+ {{SECS_W{1'b0}}, func_q};
	assign borrow = au_res[SECS_W];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		acc_upd  = 1'b0;
		y_inc    = 1'b0;
		m_inc    = 1'b0;
		cnt_inc  = 1'b0;
		cnt_clr  = 1'b0;
		sv_day   = 1'b0;
		sv_hour  = 1'b0;
		sv_min   = 1'b0;
		bad_set  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = start_bad ? ST_LOAD : ST_YEAR;
				end
			end
			ST_YEAR: begin
				if (func_q) begin
					if ((y_q == YEAR_LAST) || borrow) begin
						state_d = ST_MONTH;
					end else begin
						acc_upd = 1'b1;
						y_inc   = 1'b1;
					end
				end else if (y_q == year_q) begin
					if (day_q > month_days(month_q, leap)) begin
						bad_set = 1'b1;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_MONTH;
					end
				end else begin
					acc_upd = 1'b1;
					y_inc   = 1'b1;
				end
			end
			ST_MONTH: begin
				if (func_q ? ((m_q == MONTH_DEC) || borrow) : (m_q == month_q)) begin
					cnt_clr = 1'b1;
					state_d = ST_DAY;
				end else begin
					acc_upd = 1'b1;
					m_inc   = 1'b1;
				end
			end
			ST_DAY: begin
				if (func_q ? borrow : (cnt_nxt == {1'b0, day_q})) begin
					sv_day  = func_q;
					cnt_clr = 1'b1;
					state_d = ST_HOUR;
				end else begin
					acc_upd = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			ST_HOUR: begin
				if (func_q ? borrow : (cnt_q == {1'b0, hour_q})) begin
					sv_hour = func_q;
					cnt_clr = 1'b1;
					state_d = ST_MIN;
				end else begin
					acc_upd = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			ST_MIN: begin
				if (func_q ? borrow : (cnt_q == minute_q)) begin
					sv_min  = func_q;
					state_d = func_q ? ST_LOAD : ST_SEC;
				end else begin
					acc_upd = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			ST_SEC: begin
				acc_upd = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath: request capture, running count and calendar counters
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			func_q   <= func;
			year_q   <= year;
			month_q  <= month;
			day_q    <= day;
			hour_q   <= hour;
			minute_q <= minute;
			second_q <= second;
			acc_q    <= func ? seconds_in : '0;
			y_q      <= YEAR_FIRST;
			ym4_q    <= 2'd0;
			ym100_q  <= 7'd0;
			ym400_q  <= 9'd0;
			m_q      <= 4'd1;
			bad_q    <= start_bad;
		end else begin
			if (acc_upd) begin
				acc_q <= au_res[SECS_W-1:0];
			end
			if (y_inc) begin
				y_q     <= y_q + 12'd1;
				ym4_q   <= ym4_q + 2'd1;
				ym100_q <= (ym100_q == 7'd99) ? 7'd0 : ym100_q + 7'd1;
				ym400_q <= (ym400_q == 9'd399) ? 9'd0 : ym400_q + 9'd1;
			end
			if (m_inc) begin
				m_q <= m_q + 4'd1;
			end
			if (bad_set) begin
				bad_q <= 1'b1;
			end
		end
		if (cnt_clr) begin
			cnt_q <= 6'd0;
		end else if (cnt_inc) begin
			cnt_q <= cnt_nxt;
		end
		if (sv_day) begin
			day_w_q <= cnt_nxt[4:0];
		end
		if (sv_hour) begin
			hour_w_q <= cnt_q[4:0];
		end
		if (sv_min) begin
			min_w_q <= cnt_q;
			sec_w_q <= acc_q[5:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register payload; fields of the other mode read zero
	always_ff @(posedge clk) begin
		if (out_load) begin
			seconds_out_q <= (!func_q && !bad_q) ? acc_q : '0;
			year_out_q    <= (func_q && !bad_q) ? y_q : '0;
			month_out_q   <= (func_q && !bad_q) ? m_q : '0;
			day_out_q     <= (func_q && !bad_q) ? day_w_q : '0;
			hour_out_q    <= (func_q && !bad_q) ? hour_w_q : '0;
			minute_out_q  <= (func_q && !bad_q) ? min_w_q : '0;
			second_out_q  <= (func_q && !bad_q) ? sec_w_q : '0;
			invalid_q     <= bad_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign seconds_out = seconds_out_q;
	assign year_out    = year_out_q;
	assign month_out   = month_out_q;
	assign day_out     = day_out_q;
	assign hour_out    = hour_out_q;
	assign minute_out  = minute_out_q;
	assign second_out  = second_out_q;
	assign invalid     = invalid_q;

endmodule

`default_nettype wire

[rtl/csc_checker.sv]
// ----------------------------------------------------------------------------
// csc_checker: port-level checks of the calendar seconds converter
// Watches both channels and the response fields; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire  [csc_pkg::SECS_W-1:0]   seconds_out,
	input wire  [csc_pkg::YEAR_W-1:0]   year_out,
	input wire  [3:0]                   month_out,
	input wire  [4:0]                   day_out,
	input wire  [4:0]                   hour_out,
	input wire  [5:0]                   minute_out,
	input wire  [5:0]                   second_out,
	input wire                          invalid
);
	import csc_pkg::*;

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(seconds_out)
			&& $stable(year_out) && $stable(invalid))
		else $error("response changed while stalled");

	// the block is busy right after a request transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// an invalid response carries zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && invalid |-> seconds_out == '0 && year_out == '0
			&& month_out == 4'd0 && day_out == 5'd0)
		else $error("invalid response with nonzero fields");

	// a decomposed date is in range and carries no second count
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !invalid && year_out != '0 |-> seconds_out == '0
			&& year_out >= YEAR_FIRST && year_out <= YEAR_LAST
			&& month_out >= 4'd1 && month_out <= MONTH_DEC
			&& day_out >= 5'd1 && hour_out <= 5'd23
			&& minute_out <= 6'd59 && second_out <= 6'd59)
		else $error("decomposed date out of range");

endmodule

bind calendar_seconds_converter csc_checker u_csc_checker (.*);

`default_nettype wire
